[rtl/agcm_pkg.sv]
// shared types, constants and functions of the aes-128-gcm stream block
package agcm_pkg;

    localparam int RK_DEPTH   = 22;
    localparam int RK_AW      = 5;
    localparam int GH_DIGIT   = 8;

    localparam logic [1:0] KIND_AAD    = 2'd0;
    localparam logic [1:0] KIND_TEXT   = 2'd1;
    localparam logic [1:0] KIND_FINISH = 2'd2;
    localparam logic [1:0] KIND_UNUSED = 2'd3;

    localparam logic [2:0] ST_TEXT     = 3'd0;
    localparam logic [2:0] ST_TAG      = 3'd1;
    localparam logic [2:0] ST_MATCH    = 3'd2;
    localparam logic [2:0] ST_MISMATCH = 3'd3;
    localparam logic [2:0] ST_ORDER    = 3'd4;

    localparam logic [2:0] REG_KEY_HI   = 3'd0;
    localparam logic [2:0] REG_KEY_LO   = 3'd1;
    localparam logic [2:0] REG_NONCE_HI = 3'd2;
    localparam logic [2:0] REG_NONCE_LO = 3'd3;
    localparam logic [2:0] REG_MODE     = 3'd4;

    localparam logic [1:0] PH_AAD    = 2'd0;
    localparam logic [1:0] PH_TEXT   = 2'd1;
    localparam logic [1:0] PH_CLOSED = 2'd2;

    localparam logic [7:0] GF_POLY  = 8'h1b;
    localparam logic [7:0] GH_POLY  = 8'he1;

    typedef logic [127:0] t_block;

    // ghash multiply request and result between top and multiplier
    typedef struct packed {
        logic   start;
        t_block x;
        t_block h;
    } t_gh_req;

    typedef struct packed {
        logic   busy;
        logic   done;
        t_block z;
    } t_gh_rsp;

    function automatic logic [7:0] sbox(input logic [7:0] a);
        logic [7:0] s [256];
        s = '{
        8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
        8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
        8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
        8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
        8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
        8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
        8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
        8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
        8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
        8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
        8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
        8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
        8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
        8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
        8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
        8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16};
        return s[a];
    endfunction

    function automatic logic [7:0] xtime(input logic [7:0] a);
        return {a[6:0], 1'b0} ^ (a[7] ? GF_POLY : 8'h00);
    endfunction

    // one aes round without the key addition; last round skips mixcolumns
    function automatic t_block aes_round(input t_block s, input logic last);
        logic [7:0] b [16];
        logic [7:0] t [16];
        logic [7:0] a0, a1, a2, a3, al;
        t_block r;
        for (int i = 0; i < 16; i++) b[i] = s[127 - 8 * i -: 8];
        for (int i = 0; i < 16; i++) t[i] = sbox(b[(i + 4 * (i % 4)) % 16]);
        if (!last) begin
            for (int c = 0; c < 16; c += 4) begin
                a0 = t[c]; a1 = t[c + 1]; a2 = t[c + 2]; a3 = t[c + 3];
                al = a0 ^ a1 ^ a2 ^ a3;
                t[c]     = a0 ^ al ^ xtime(a0 ^ a1);
                t[c + 1] = a1 ^ al ^ xtime(a1 ^ a2);
                t[c + 2] = a2 ^ al ^ xtime(a2 ^ a3);
                t[c + 3] = a3 ^ al ^ xtime(a3 ^ a0);
            end
        end
        for (int i = 0; i < 16; i++) r[127 - 8 * i -: 8] = t[i];
        return r;
    endfunction

    function automatic t_block byte_mask(input logic [4:0] n);
        t_block m;
        for (int i = 0; i < 16; i++) m[127 - 8 * i -: 8] = (5'(i) < n) ? 8'hff : 8'h00;
        return m;
    endfunction

endpackage

[rtl/agcm_ram.sv]
// generic single-port-write ram with registered read
module agcm_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 22
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) r_mem[i_waddr] <= i_wdata;
        o_rdata <= r_mem[i_raddr];
    end
endmodule

[rtl/agcm_ghash.sv]
// digit-serial gf(2^128) multiplier, eight bits of x per cycle
module agcm_ghash (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  agcm_pkg::t_gh_req i_req,
    output agcm_pkg::t_gh_rsp o_rsp
);
    import agcm_pkg::*;

    localparam int STEPS = 128 / GH_DIGIT;

    logic [$clog2(STEPS+1)-1:0] r_cnt, n_cnt;
    t_block r_x, r_v, r_z, n_x, n_v, n_z;
    logic   r_busy, n_busy, r_done, n_done;

    always_comb begin
        n_x = r_x; n_v = r_v; n_z = r_z; n_cnt = r_cnt;
        n_busy = r_busy; n_done = 1'b0;
        if (i_req.start) begin
            n_x = i_req.x; n_v = i_req.h; n_z = '0;
            n_cnt = '0; n_busy = 1'b1;
        end else if (r_busy) begin
            for (int b = 0; b < GH_DIGIT; b++) begin
                if (n_x[127]) n_z = n_z ^ n_v;
                n_v = {1'b0, n_v[127:1]} ^ (n_v[0] ? {GH_POLY, 120'd0} : 128'd0);
                n_x = {n_x[126:0], 1'b0};
            end
            n_cnt = r_cnt + 1'b1;
            if (n_cnt == ($clog2(STEPS+1))'(STEPS)) begin
                n_busy = 1'b0; n_done = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0; r_done <= 1'b0; r_cnt <= '0;
        end else begin
            r_busy <= n_busy; r_done <= n_done; r_cnt <= n_cnt;
        end
        r_x <= n_x; r_v <= n_v; r_z <= n_z;
    end

    assign o_rsp.busy = r_busy;
    assign o_rsp.done = r_done;
    assign o_rsp.z    = r_z;

    a_done_after_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_done |-> $past(r_busy)) else $error("ghash done without busy");
    a_no_restart: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_busy |-> !i_req.start) else $error("ghash restarted while busy");
    a_done_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_done |-> !r_busy) else $error("ghash done and busy");
endmodule

[rtl/aes128_gcm_stream.sv]
// top level of the aes-128-gcm stream block: key schedule, round sequencer, message control
// Each item is one request. After reset, and again after a key write, the
// block expands the key into the round-key ram (two 64-bit words per round
// key, one word per cycle) and derives H; it accepts no item meanwhile.
// A text block runs eleven key additions through one round unit, each in the
// states ARD0, ARD1 and AROUND, since each round key is read from the ram as
// two words, then the ghash fold on an eight-bit digit-serial multiplier in 16
// digit steps, and loads the result in DONE. An aad block runs only the fold,
// a finish item the fold of the length block and then the tag cipher pass; an
// empty text block or an out-of-order item is answered from idle. One item is
// in work at a time; a finished result waits in the output register while the
// next item is taken, and only an item whose result is due at once is held off by it.
module aes128_gcm_stream (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic [1:0]  i_kind,
    input  logic [63:0] i_block_high,
    input  logic [63:0] i_block_low,
    input  logic [4:0]  i_byte_count,
    output logic        o_valid,
    input  logic        i_stall,
    output logic [63:0] o_out_high,
    output logic [63:0] o_out_low,
    output logic [4:0]  o_out_bytes,
    output logic [2:0]  o_status,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [2:0]  i_cfg_index,
    input  logic [63:0] i_cfg_data
);
    import agcm_pkg::*;

    typedef enum logic [8:0] {
        S_KEXP  = 9'b000000001,
        S_HSTRT = 9'b000000010,
        S_IDLE  = 9'b000000100,
        S_ARD0  = 9'b000001000,
        S_ARD1  = 9'b000010000,
        S_AROUND= 9'b000100000,
        S_GSTRT = 9'b001000000,
        S_GWAIT = 9'b010000000,
        S_DONE  = 9'b100000000
    } t_state;

    // what the cipher pass is for
    typedef enum logic [3:0] {
        J_H    = 4'b0001,
        J_TEXT = 4'b0010,
        J_TAG  = 4'b0100,
        J_NONE = 4'b1000
    } t_job;

    t_state r_state, n_state;
    t_job   r_job, n_job;

    logic [63:0] r_key_hi, r_key_lo, r_nonce_hi;
    logic [31:0] r_nonce_lo;
    logic        r_mode;
    logic        r_rekey;

    t_block r_h, r_acc, r_s, r_kw, r_blk, r_ct;
    logic [31:0] r_ctr;
    logic [60:0] r_aad_tot, r_txt_tot;
    logic [1:0]  r_phase;
    logic [4:0]  r_cnt;
    logic [3:0]  r_rnd, r_ki;
    logic [63:0] r_rkhi;
    logic        r_kstep;
    logic        r_fin_fold;
    logic [7:0]  r_rcon;

    logic        r_ovalid;
    logic [63:0] r_ohi, r_olo;
    logic [4:0]  r_obytes;
    logic [2:0]  r_ostat;

    logic            ram_we;
    logic [RK_AW-1:0] ram_waddr, ram_raddr;
    logic [63:0]     ram_wdata, ram_rdata;
    t_gh_req gh_req;
    t_gh_rsp gh_rsp;

    agcm_ram #(.WIDTH(64), .DEPTH(RK_DEPTH)) u_rk (
        .i_clk(i_clk), .i_we(ram_we), .i_waddr(ram_waddr), .i_wdata(ram_wdata),
        .i_raddr(ram_raddr), .o_rdata(ram_rdata));

    agcm_ghash u_gh (.i_clk(i_clk), .i_rst_n(i_rst_n), .i_req(gh_req), .o_rsp(gh_rsp));

    t_block mask_in, blk_m, txt_out, fin_len;
    logic   ord_err, imm_res;
    assign mask_in = byte_mask(i_byte_count);
    assign blk_m   = {i_block_high, i_block_low} & mask_in;
    assign ord_err = (i_kind == KIND_UNUSED) || (i_byte_count > 5'd16) ||
                     (i_kind == KIND_AAD && r_phase != PH_AAD) ||
                     (i_kind == KIND_TEXT && r_phase == PH_CLOSED);
    // items whose result goes straight into the output register
    assign imm_res = (i_kind != KIND_FINISH) &&
                     (ord_err || (i_kind == KIND_TEXT && i_byte_count == 5'd0));
    assign txt_out = (r_blk ^ r_s) & byte_mask(r_cnt);
    assign fin_len = {r_aad_tot, 3'b000, r_txt_tot, 3'b000};

    logic cfg_wr, acc_in, out_free;
    assign o_cfg_ready = 1'b1;
    assign cfg_wr  = i_cfg_valid;
    assign out_free = !r_ovalid || !i_stall;
    assign o_stall = !(r_state == S_IDLE) || r_rekey || (imm_res && !out_free);
    assign acc_in  = i_valid && !o_stall;

    // next round key word from the previous one
    t_block kw_next;
    always_comb begin
        logic [31:0] w3, t;
        w3 = r_kw[31:0];
        t = {sbox(w3[23:16]), sbox(w3[15:8]), sbox(w3[7:0]), sbox(w3[31:24])};
        t[31:24] = t[31:24] ^ r_rcon;
        kw_next[127:96] = r_kw[127:96] ^ t;
        kw_next[95:64]  = r_kw[95:64] ^ kw_next[127:96];
        kw_next[63:32]  = r_kw[63:32] ^ kw_next[95:64];
        kw_next[31:0]   = r_kw[31:0] ^ kw_next[63:32];
    end

    always_comb begin
        ram_we = 1'b0; ram_waddr = {r_ki, 1'b0}; ram_wdata = r_kw[127:64];
        ram_raddr = {r_rnd, 1'b0};
        if (r_state == S_KEXP) begin
            ram_we = 1'b1;
            ram_waddr = {r_ki, r_kstep};
            ram_wdata = r_kstep ? r_kw[63:0] : r_kw[127:64];
        end else if (r_state == S_ARD1) begin
            ram_raddr = {r_rnd, 1'b1};
        end
    end

    always_comb begin
        gh_req.start = 1'b0;
        gh_req.x = r_acc ^ r_ct;
        gh_req.h = r_h;
        if (r_state == S_GSTRT) gh_req.start = 1'b1;
    end

    always_comb begin
        n_state = r_state;
        n_job = r_job;
        unique case (r_state)
            S_KEXP:  if (r_kstep && r_ki == 4'd10) n_state = S_HSTRT;
            S_HSTRT: begin
                n_state = S_ARD0; n_job = J_H;
            end
            S_IDLE: begin
                if (r_rekey) begin
                    if (!cfg_wr) n_state = S_KEXP;
                end else if (acc_in) begin
                    if (i_kind == KIND_FINISH) begin
                        n_job = J_TAG; n_state = S_GSTRT;
                    end else if (ord_err) n_state = S_IDLE;
                    else if (i_kind == KIND_AAD) begin
                        n_job = J_NONE;
                        n_state = (i_byte_count != 5'd0) ? S_GSTRT : S_IDLE;
                    end else begin
                        n_job = J_TEXT;
                        n_state = (i_byte_count != 5'd0) ? S_ARD0 : S_IDLE;
                    end
                end
            end
            S_ARD0:  n_state = S_ARD1;
            S_ARD1:  n_state = S_AROUND;
            S_AROUND: begin
                if (r_rnd == 4'd10) begin
                    unique case (r_job)
                        J_H:    n_state = S_IDLE;
                        J_TEXT: n_state = S_GSTRT;
                        J_TAG:  n_state = S_DONE;
                        J_NONE: n_state = S_IDLE;
                        default: n_state = S_IDLE;
                    endcase
                end else n_state = S_ARD0;
            end
            S_GSTRT: n_state = S_GWAIT;
            S_GWAIT: begin
                if (gh_rsp.done) begin
                    if (r_job == J_TAG) n_state = r_fin_fold ? S_DONE : S_ARD0;
                    else n_state = (r_job == J_TEXT) ? S_DONE : S_IDLE;
                end
            end
            S_DONE:  if (out_free) n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_KEXP; r_job <= J_H;
            r_key_hi <= '0; r_key_lo <= '0; r_nonce_hi <= '0; r_nonce_lo <= '0;
            r_mode <= 1'b0; r_rekey <= 1'b0;
            r_acc <= '0; r_ctr <= 32'd1; r_aad_tot <= '0; r_txt_tot <= '0;
            r_phase <= PH_AAD; r_ovalid <= 1'b0;
            r_kw <= '0; r_ki <= '0; r_kstep <= 1'b0; r_rcon <= 8'h01;
            r_rnd <= '0; r_fin_fold <= 1'b0;
        end else begin
            r_state <= n_state;
            r_job <= n_job;
            if (r_ovalid && !i_stall) r_ovalid <= 1'b0;
            if (cfg_wr) begin
                unique case (i_cfg_index)
                    REG_KEY_HI:   begin r_key_hi <= i_cfg_data; r_rekey <= 1'b1; end
                    REG_KEY_LO:   begin r_key_lo <= i_cfg_data; r_rekey <= 1'b1; end
                    REG_NONCE_HI: r_nonce_hi <= i_cfg_data;
                    REG_NONCE_LO: r_nonce_lo <= i_cfg_data[31:0];
                    REG_MODE:     r_mode <= i_cfg_data[0];
                    default: ;
                endcase
            end
            unique case (r_state)
                S_KEXP: begin
                    r_kstep <= !r_kstep;
                    if (r_kstep) begin
                        r_kw <= kw_next;
                        r_ki <= r_ki + 1'b1;
                        r_rcon <= xtime(r_rcon);
                    end
                end
                S_HSTRT: begin
                    r_s <= '0; r_rnd <= '0;
                end
                S_IDLE: begin
                    if (r_rekey && !cfg_wr) begin
                        r_rekey <= 1'b0;
                        r_kw <= {r_key_hi, r_key_lo}; r_ki <= '0; r_kstep <= 1'b0;
                        r_rcon <= 8'h01;
                    end
                    if (acc_in) begin
                        r_cnt <= i_byte_count; r_blk <= blk_m;
                        r_rnd <= '0;
                        if (i_kind == KIND_FINISH) begin
                            r_blk <= {i_block_high, i_block_low};
                            r_ct <= fin_len; r_fin_fold <= 1'b0;
                            r_s <= {r_nonce_hi, r_nonce_lo, 32'd1};
                        end else if (ord_err) begin
                            r_ovalid <= 1'b1; r_ohi <= '0; r_olo <= '0;
                            r_obytes <= '0; r_ostat <= ST_ORDER;
                        end else if (i_kind == KIND_AAD) begin
                            r_ct <= blk_m;
                            r_aad_tot <= r_aad_tot + 61'(i_byte_count);
                            if (i_byte_count < 5'd16) r_phase <= PH_TEXT;
                        end else begin
                            r_phase <= (i_byte_count < 5'd16) ? PH_CLOSED : PH_TEXT;
                            if (i_byte_count == 5'd0) begin
                                r_ovalid <= 1'b1; r_ohi <= '0; r_olo <= '0;
                                r_obytes <= '0; r_ostat <= ST_TEXT;
                            end else begin
                                r_ctr <= r_ctr + 32'd1;
                                r_s <= {r_nonce_hi, r_nonce_lo, r_ctr + 32'd1};
                                r_txt_tot <= r_txt_tot + 61'(i_byte_count);
                            end
                        end
                    end
                end
                S_ARD1: r_rkhi <= ram_rdata;
                S_AROUND: begin
                    if (r_rnd == 4'd0) r_s <= r_s ^ {r_rkhi, ram_rdata};
                    else r_s <= aes_round(r_s, r_rnd == 4'd10) ^ {r_rkhi, ram_rdata};
                    r_rnd <= r_rnd + 1'b1;
                    if (r_rnd == 4'd10) begin
                        if (r_job == J_H) r_h <= aes_round(r_s, 1'b1) ^ {r_rkhi, ram_rdata};
                        if (r_job == J_TEXT)
                            r_ct <= r_mode ? r_blk
                                : ((r_blk ^ (aes_round(r_s, 1'b1) ^ {r_rkhi, ram_rdata}))
                                   & byte_mask(r_cnt));
                    end
                end
                S_GWAIT: begin
                    if (gh_rsp.done) begin
                        r_acc <= gh_rsp.z;
                        if (r_job == J_TAG) r_fin_fold <= 1'b1;
                    end
                end
                S_DONE: begin
                    if (out_free) begin
                        r_ovalid <= 1'b1;
                        if (r_job == J_TEXT) begin
                            r_ohi <= txt_out[127:64]; r_olo <= txt_out[63:0];
                            r_obytes <= r_cnt; r_ostat <= ST_TEXT;
                        end else begin
                            if (r_mode) begin
                                r_ohi <= '0; r_olo <= '0; r_obytes <= '0;
                                r_ostat <= ((r_s ^ r_acc) == r_blk) ? ST_MATCH : ST_MISMATCH;
                            end else begin
                                r_ohi <= r_s[127:64] ^ r_acc[127:64];
                                r_olo <= r_s[63:0] ^ r_acc[63:0];
                                r_obytes <= 5'd16; r_ostat <= ST_TAG;
                            end
                            r_acc <= '0; r_ctr <= 32'd1; r_aad_tot <= '0;
                            r_txt_tot <= '0; r_phase <= PH_AAD;
                        end
                    end
                end
                default: ;
            endcase
        end
    end

    assign o_valid     = r_ovalid;
    assign o_out_high  = r_ohi;
    assign o_out_low   = r_olo;
    assign o_out_bytes = r_obytes;
    assign o_status    = r_ostat;

    a_stall_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != S_IDLE) |-> o_stall) else $error("item taken while busy");
    a_kexp_write: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ram_we |-> (r_state == S_KEXP)) else $error("round key write outside expansion");
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_ovalid && i_stall) |=> r_ovalid) else $error("result lost while stalled");
    a_ctr_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (acc_in && i_kind == KIND_TEXT && !ord_err && i_byte_count != 5'd0)
        |=> r_ctr == $past(r_ctr) + 32'd1) else $error("counter did not advance");
endmodule
